// ----- hw/rtl/atrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package atrp_pkg;
	localparam int unsigned STAGES = 16;
	localparam int unsigned TABLE_LEN = 24;
	localparam int unsigned N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
	localparam int unsigned FRAC_BITS = 14;
	localparam int unsigned ANG_FRAC = 12;
	// vector width: 17-bit input scaled by 2^14, cordic gain < 1.65, sqrt2
	localparam int unsigned VW = 34;
	localparam int unsigned ZW = 28;
	localparam int unsigned MW = 17;
	localparam logic signed [31:0] INVK_Q30 = 32'sd652032874;
	localparam logic signed [14:0] MAX_CD = 15'sd9000;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic ang_t atan_entry(input int unsigned i);
		logic [24:0] t;
		case (i)
			0: t = 25'd18432000;
			1: t = 25'd10881045;
			2: t = 25'd5749245;
			3: t = 25'd2918407;
			4: t = 25'd1464867;
			5: t = 25'd733147;
			6: t = 25'd366663;
			7: t = 25'd183343;
			8: t = 25'd91673;
			9: t = 25'd45837;
			10: t = 25'd22918;
			11: t = 25'd11459;
			12: t = 25'd5730;
			13: t = 25'd2865;
			14: t = 25'd1432;
			15: t = 25'd716;
			16: t = 25'd358;
			17: t = 25'd179;
			18: t = 25'd90;
			19: t = 25'd45;
			20: t = 25'd22;
			21: t = 25'd11;
			22: t = 25'd6;
			23: t = 25'd3;
			default: t = 25'd0;
		endcase
		return ang_t'({3'b000, t});
	endfunction

	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
	} cell_data_t;
endpackage
`default_nettype wire

// ----- hw/rtl/atrp_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one cordic vectoring iteration, registered; shift amount and angle set by stage input
module atrp_cell (
	input  wire                       clk,
	input  wire                       en,
	input  wire  [4:0]                shift,
	input  wire  atrp_pkg::ang_t      angle,
	input  wire  atrp_pkg::cell_data_t d,
	output atrp_pkg::cell_data_t      q
);
	atrp_pkg::vec_t xs;
	atrp_pkg::vec_t ys;
	atrp_pkg::cell_data_t nxt;

	always_comb begin
		xs = d.x >>> shift;
		ys = d.y >>> shift;
		if (!d.y[atrp_pkg::VW-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + angle;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - angle;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/atrp_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// row of cordic cells, one iteration per cell, advancing on en
module atrp_chain (
	input  wire                        clk,
	input  wire                        en,
	input  wire  atrp_pkg::cell_data_t d,
	output atrp_pkg::cell_data_t       q
);
	atrp_pkg::cell_data_t link [atrp_pkg::N+1];

	assign link[0] = d;
	assign q = link[atrp_pkg::N];

	for (genvar i = 0; i < atrp_pkg::N; i++) begin : g_cell
		atrp_cell u_cell (
			.clk   (clk),
			.en    (en),
			.shift (5'(i)),
			.angle (atrp_pkg::atan_entry(i)),
			.d     (link[i]),
			.q     (link[i+1])
		);
	end
endmodule
`default_nettype wire

// ----- hw/rtl/accel_tilt_roll_pitch_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Tilt angles from one accelerometer beat: roll = atan2(y, |x,z|) and pitch = atan2(-x, |y,z|)
// in signed centidegrees. Two rows of cordic cells per angle (magnitude, then angle) plus
// scale and rounding stages form one pipeline that takes a beat every cycle while the output
// does not stall. The whole pipeline advances only when the output register is free or being
// taken, so a stall at the output holds every stage.
module accel_tilt_roll_pitch_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata    // roll_centideg[14:0], pitch_centideg[29:15], zero pad
);
	localparam int unsigned LAT = 2 * atrp_pkg::N + 4;
	localparam int unsigned FB = atrp_pkg::FRAC_BITS;
	localparam int unsigned VW = atrp_pkg::VW;

	logic en;
	// one valid bit per data stage ahead of the output register
	logic [LAT-2:0] vld_q;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-3:0], s_tvalid};
			m_tvalid <= vld_q[LAT-2];
		end
	end

	// stage 1: magnitude cordic inputs, numerators kept alongside
	logic signed [16:0] ax, ay, az;
	atrp_pkg::cell_data_t mr_s1, mp_s1, mr_o, mp_o;
	logic signed [16:0] nr_s1, np_s1;
	assign ax = 17'(signed'(s_tdata[15:0]));
	assign ay = 17'(signed'(s_tdata[31:16]));
	assign az = 17'(signed'(s_tdata[47:32]));

	always_ff @(posedge clk) begin
		if (en) begin
			mr_s1.x <= VW'(ax[16] ? -ax : ax) <<< FB;
			mr_s1.y <= VW'(az) <<< FB;
			mr_s1.z <= '0;
			mp_s1.x <= VW'(ay[16] ? -ay : ay) <<< FB;
			mp_s1.y <= VW'(az) <<< FB;
			mp_s1.z <= '0;
			nr_s1 <= ay;
			np_s1 <= -ax;
		end
	end

	atrp_chain u_mag_r (.clk(clk), .en(en), .d(mr_s1), .q(mr_o));
	atrp_chain u_mag_p (.clk(clk), .en(en), .d(mp_s1), .q(mp_o));

	// numerators ride alongside the magnitude cells
	logic signed [16:0] nr_d [atrp_pkg::N];
	logic signed [16:0] np_d [atrp_pkg::N];
	always_ff @(posedge clk) begin
		if (en) begin
			nr_d[0] <= nr_s1;
			np_d[0] <= np_s1;
			for (int i = 1; i < atrp_pkg::N; i++) begin
				nr_d[i] <= nr_d[i-1];
				np_d[i] <= np_d[i-1];
			end
		end
	end

	// scale by 1/K
	logic signed [VW+31:0] pr_s2, pp_s2;
	logic signed [16:0] nr_s2, np_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2 <= (VW+32)'(mr_o.x) * (VW+32)'(atrp_pkg::INVK_Q30);
			pp_s2 <= (VW+32)'(mp_o.x) * (VW+32)'(atrp_pkg::INVK_Q30);
			nr_s2 <= nr_d[atrp_pkg::N-1];
			np_s2 <= np_d[atrp_pkg::N-1];
		end
	end

	logic signed [VW+31:0] rr, rp;
	assign rr = (pr_s2 + (VW+32)'(64'sd1 <<< 29)) >>> 30;
	assign rp = (pp_s2 + (VW+32)'(64'sd1 <<< 29)) >>> 30;

	atrp_pkg::cell_data_t ar_s3, ap_s3, ar_o, ap_o;
	always_ff @(posedge clk) begin
		if (en) begin
			ar_s3.x <= VW'(rr);
			ar_s3.y <= VW'(nr_s2) <<< FB;
			ar_s3.z <= '0;
			ap_s3.x <= VW'(rp);
			ap_s3.y <= VW'(np_s2) <<< FB;
			ap_s3.z <= '0;
		end
	end

	atrp_chain u_ang_r (.clk(clk), .en(en), .d(ar_s3), .q(ar_o));
	atrp_chain u_ang_p (.clk(clk), .en(en), .d(ap_s3), .q(ap_o));

	// special-case flags: 2 bits per angle, {zero numerator, zero magnitude}
	// entry 0 sits beside the angle inputs, entry N beside the angle outputs
	logic [3:0] fl_d [atrp_pkg::N+1];
	logic sr_d [atrp_pkg::N+1];
	logic sp_d [atrp_pkg::N+1];
	always_ff @(posedge clk) begin
		if (en) begin
			fl_d[0] <= {nr_s2 == 0, rr == 0, np_s2 == 0, rp == 0};
			sr_d[0] <= nr_s2[16];
			sp_d[0] <= np_s2[16];
			for (int i = 1; i <= atrp_pkg::N; i++) begin
				fl_d[i] <= fl_d[i-1];
				sr_d[i] <= sr_d[i-1];
				sp_d[i] <= sp_d[i-1];
			end
		end
	end

	function automatic logic [14:0] finish(input atrp_pkg::ang_t z, input logic zn,
		input logic zm, input logic neg);
		atrp_pkg::ang_t r;
		r = (z + atrp_pkg::ang_t'(1 << (atrp_pkg::ANG_FRAC - 1))) >>> atrp_pkg::ANG_FRAC;
		if (zn) return 15'sd0;
		if (zm) return neg ? -atrp_pkg::MAX_CD : atrp_pkg::MAX_CD;
		if (r > atrp_pkg::ZW'(atrp_pkg::MAX_CD)) return atrp_pkg::MAX_CD;
		if (r < -atrp_pkg::ZW'(atrp_pkg::MAX_CD)) return -atrp_pkg::MAX_CD;
		return r[14:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {2'b00,
				finish(ap_o.z, fl_d[atrp_pkg::N][1], fl_d[atrp_pkg::N][0],
					sp_d[atrp_pkg::N]),
				finish(ar_o.z, fl_d[atrp_pkg::N][3], fl_d[atrp_pkg::N][2],
					sr_d[atrp_pkg::N])};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_frz: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import atrp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int errors = 0;
	bit send_done = 0;

	always #6 clk = ~clk;

	accel_tilt_roll_pitch_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// floor shift on 64-bit signed
	function automatic longint sra(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint cordic_mag(input longint a, input longint b);
		longint x, y, xs, ys;
		x = (a < 0 ? -a : a) <<< FRAC_BITS;
		y = b <<< FRAC_BITS;
		for (int i = 0; i < N; i++) begin
			xs = sra(x, i);
			ys = sra(y, i);
			if (y >= 0) begin
				x += ys; y -= xs;
			end else begin
				x -= ys; y += xs;
			end
		end
		return (x * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint tilt_centideg(input longint num, input longint mag);
		longint x, y, z, xs, ys, r;
		if (num == 0) return 0;
		if (mag == 0) return num > 0 ? 9000 : -9000;
		x = mag;
		y = num <<< FRAC_BITS;
		z = 0;
		for (int i = 0; i < N; i++) begin
			xs = sra(x, i);
			ys = sra(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(atan_entry(i));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_entry(i));
			end
		end
		r = sra(z + (64'sd1 <<< (ANG_FRAC - 1)), ANG_FRAC);
		if (r > 9000) r = 9000;
		if (r < -9000) r = -9000;
		return r;
	endfunction

	class tilt_scoreboard;
		logic [14:0] roll_q[$];
		logic [14:0] pitch_q[$];
		int checked = 0;

		function void note_sample(logic [47:0] d);
			longint ax, ay, az;
			ax = longint'($signed(d[15:0]));
			ay = longint'($signed(d[31:16]));
			az = longint'($signed(d[47:32]));
			roll_q.push_back(15'(tilt_centideg(ay, cordic_mag(ax, az))));
			pitch_q.push_back(15'(tilt_centideg(-ax, cordic_mag(ay, az))));
		endfunction

		task check_angles(logic [31:0] d);
			logic [14:0] r, p;
			if (roll_q.size() == 0) begin
				report("unexpected beat", int'(d), 0);
				return;
			end
			r = roll_q.pop_front();
			p = pitch_q.pop_front();
			checked++;
			if (d[14:0] !== r) report("roll", $signed(d[14:0]), $signed(r));
			if (d[29:15] !== p) report("pitch", $signed(d[29:15]), $signed(p));
			if (d[31:30] !== 2'b00) report("pad", int'(d[31:30]), 0);
		endtask

		function int pending();
			return roll_q.size();
		endfunction
	endclass

	tilt_scoreboard sb = new();

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			3: return 16'(int'($urandom_range(0, 40000)) - 20000);
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_sample(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_angles(m_tdata);
	end

	bit quiet_rx = 0;
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet_rx) m_tready <= 1'b1;
			else begin
				g = gap_len();
				if (g == 0) m_tready <= 1'b1;
				else begin
					m_tready <= 1'b0;
					repeat (g) @(negedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	task automatic send_sample(input logic [15:0] ax, ay, az, input bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {az, ay, ax};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0100};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: all zero, pure axes, extremes, zero magnitude cases
		send_sample(16'h0000, 16'h0000, 16'h0000, 0);
		send_sample(16'h8000, 16'h0000, 16'h0000, 0);
		send_sample(16'h7fff, 16'h0000, 16'h0000, 0);
		send_sample(16'h0000, 16'h8000, 16'h0000, 0);
		send_sample(16'h0000, 16'h7fff, 16'h0000, 0);
		send_sample(16'h0000, 16'h0000, 16'h8000, 0);
		send_sample(16'h0000, 16'h0000, 16'h7fff, 0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 0);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_sample(16'h8000, 16'h7fff, 16'h0000, 0);
		send_sample(16'h0001, 16'hffff, 16'h0000, 0);
		for (int i = 0; i < 12; i++)
			send_sample(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
				ext[$urandom_range(0, 5)], 0);
		drain();
		// back to back burst with the receiver always ready
		quiet_rx = 1;
		for (int i = 0; i < 200; i++)
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1);
		drain();
		quiet_rx = 0;
		for (int i = 0; i < 1200; i++) begin
			send_sample(rand_axis(), rand_axis(), rand_axis(), i % 300 < 100);
			if (i == 600) drain();
		end
		s_tvalid <= 1'b0;
		send_done = 1;
	end

	initial begin
		wait (send_done);
		while (sb.pending() != 0) @(negedge clk);
		repeat (2 * STAGES + 20) @(negedge clk);
		$display("checked %0d samples: axis extremes, zero vectors, bursts and random stalls",
			sb.checked);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/atrp_pkg.sv
hw/rtl/atrp_cell.sv
hw/rtl/atrp_chain.sv
hw/rtl/accel_tilt_roll_pitch_unit.sv
tb/testbench.sv
